[rtl/cpu16_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cpu16_pkg;

	typedef logic [3:0] code_t;

	localparam code_t OP_ALU  = 4'd0;
	localparam code_t OP_ASR  = 4'd1;
	localparam code_t OP_LSR  = 4'd2;
	localparam code_t OP_LSL  = 4'd3;
	localparam code_t OP_ROR  = 4'd4;
	localparam code_t OP_ROL  = 4'd5;
	localparam code_t OP_MULU = 4'd6;
	localparam code_t OP_MULS = 4'd7;
	localparam code_t OP_BR   = 4'd8;
	localparam code_t OP_LDST = 4'd9;

	localparam code_t ALU_ADD  = 4'd0;
	localparam code_t ALU_ADC  = 4'd1;
	localparam code_t ALU_SUB  = 4'd2;
	localparam code_t ALU_SBC  = 4'd3;
	localparam code_t ALU_CMP  = 4'd4;
	localparam code_t ALU_NEG  = 4'd6;
	localparam code_t ALU_XOR  = 4'd8;
	localparam code_t ALU_LOAD = 4'd9;
	localparam code_t ALU_OR   = 4'd10;
	localparam code_t ALU_AND  = 4'd11;
	localparam code_t ALU_TEST = 4'd12;

	localparam code_t CC_CC    = 4'd0;
	localparam code_t CC_CS    = 4'd1;
	localparam code_t CC_SC    = 4'd2;
	localparam code_t CC_SS    = 4'd3;
	localparam code_t CC_NE    = 4'd4;
	localparam code_t CC_EQ    = 4'd5;
	localparam code_t CC_PL    = 4'd6;
	localparam code_t CC_MI    = 4'd7;
	localparam code_t CC_LS    = 4'd8;
	localparam code_t CC_HI    = 4'd9;
	localparam code_t CC_LE    = 4'd10;
	localparam code_t CC_GT    = 4'd11;
	localparam code_t CC_NV0   = 4'd12;
	localparam code_t CC_NV1   = 4'd13;
	localparam code_t CC_AL    = 4'd14;
	localparam code_t CC_BAD   = 4'd15;

	localparam int FL_N = 3;
	localparam int FL_Z = 2;
	localparam int FL_S = 1;
	localparam int FL_C = 0;

endpackage

`default_nettype wire

[rtl/cpu16_alu_shifter_flags_top.sv]
// Execute datapath: input register, combinational ALU/shift/multiply logic, result register.
// out_valid rises once a transaction has passed through the input and result registers.
// One transaction per cycle unless stalled; flags and shift buffer update in the compute cycle.
// Both stages stall together when the result register is full and not taken.
// arst_n clears the stage valids, flags and shift buffer at once.
`timescale 1ns / 1ps
`default_nettype none

module cpu16_alu_shifter_flags_top
	import cpu16_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  operation,
	input  wire logic [3:0]  alu_code,
	input  wire logic [15:0] operand_a,
	input  wire logic [15:0] operand_b,
	input  wire logic [2:0]  shift_count,
	input  wire logic        backward,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      result,
	output logic [15:0]      result_high,
	output logic             write_result,
	output logic             branch_taken,
	output logic [3:0]       flags_out,
	output logic [3:0]       shift_buffer_out,
	output logic             error
);

	logic        valid_s1;
	code_t       op_s1;
	code_t       code_s1;
	logic [15:0] a_s1;
	logic [15:0] b_s1;
	logic [2:0]  cnt_s1;
	logic        back_s1;

	logic        valid_s2;
	logic [15:0] result_s2;
	logic [15:0] result_high_s2;
	logic        write_s2;
	logic        taken_s2;
	logic [3:0]  flags_s2;
	logic [3:0]  sb_s2;
	logic        error_s2;

	logic [3:0]  flags_q;
	logic [3:0]  sb_q;

	logic        adv;
	logic        fire;

	logic [1:0]  nm1;
	logic [2:0]  n;
	logic [19:0] asr_t;
	logic [19:0] lsr_t;
	logic [23:0] ror_t;
	logic [27:0] rol_t;
	logic [23:0] lsl_t;
	logic [15:0] alu_b;
	logic [16:0] alu_v;
	logic        alu_ok;
	logic        alu_sc;
	logic        alu_wr;
	logic        alu_slt;
	logic [3:0]  alu_f;
	logic [33:0] prod;
	logic        cond;

	logic        ok_c;
	logic [15:0] res_c;
	logic [15:0] hi_c;
	logic        wr_c;
	logic        tk_c;
	logic [3:0]  f_c;
	logic [3:0]  sb_c;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			code_s1 <= alu_code;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
			cnt_s1  <= shift_count;
			back_s1 <= backward;
		end
	end

	always_comb begin
		nm1   = cnt_s1[1:0] - 2'd1;
		n     = {1'b0, nm1} + 3'd1;
		asr_t = 20'($signed({b_s1, sb_q}) >>> n);
		lsr_t = {b_s1, sb_q} >> n;
		ror_t = {sb_q, b_s1, sb_q} >> n;
		rol_t = {4'b0, sb_q, b_s1, sb_q} << n;
		lsl_t = {4'b0, sb_q, b_s1} << n;
		alu_b = (op_s1 == OP_LSL) ? lsl_t[15:0] : b_s1;

		alu_ok  = 1'b1;
		alu_sc  = 1'b0;
		alu_v   = '0;
		alu_slt = $signed(a_s1) < $signed(alu_b);
		unique case (code_s1)
			ALU_ADD: begin
				alu_v  = {1'b0, a_s1} + {1'b0, alu_b};
				alu_sc = 1'b1;
			end
			ALU_ADC: begin
				alu_v  = {1'b0, a_s1} + {1'b0, alu_b} + {16'b0, flags_q[FL_C]};
				alu_sc = 1'b1;
			end
			ALU_SBC: begin
				alu_v  = {1'b0, a_s1} + {1'b0, ~alu_b} + {16'b0, flags_q[FL_C]};
				alu_sc = 1'b1;
			end
			ALU_SUB, ALU_CMP: begin
				alu_v  = {1'b0, a_s1} + {1'b0, ~alu_b} + 17'd1;
				alu_sc = 1'b1;
			end
			ALU_NEG:  alu_v = 17'd0 - {1'b0, alu_b};
			ALU_XOR:  alu_v = {1'b0, a_s1 ^ alu_b};
			ALU_LOAD: alu_v = {1'b0, alu_b};
			ALU_OR:   alu_v = {1'b0, a_s1 | alu_b};
			ALU_AND, ALU_TEST: alu_v = {1'b0, a_s1 & alu_b};
			default:  alu_ok = 1'b0;
		endcase
		alu_wr = (code_s1 != ALU_CMP) && (code_s1 < ALU_TEST);
		alu_f  = {alu_v[15], alu_v[15:0] == 16'd0,
			alu_sc ? alu_slt : flags_q[FL_S],
			alu_sc ? alu_v[16] : flags_q[FL_C]};

		prod = 34'($signed({op_s1 == OP_MULS && a_s1[15], a_s1})
			* $signed({b_s1[15], b_s1}));

		unique case (code_s1)
			CC_CC:  cond = !flags_q[FL_C];
			CC_CS:  cond = flags_q[FL_C];
			CC_SC:  cond = !flags_q[FL_S];
			CC_SS:  cond = flags_q[FL_S];
			CC_NE:  cond = !flags_q[FL_Z];
			CC_EQ:  cond = flags_q[FL_Z];
			CC_PL:  cond = !flags_q[FL_N];
			CC_MI:  cond = flags_q[FL_N];
			CC_LS:  cond = !(flags_q[FL_C] && !flags_q[FL_Z]);
			CC_HI:  cond = flags_q[FL_C] && !flags_q[FL_Z];
			CC_LE:  cond = flags_q[FL_Z] || flags_q[FL_S];
			CC_GT:  cond = !(flags_q[FL_Z] || flags_q[FL_S]);
			CC_AL:  cond = 1'b1;
			default: cond = 1'b0;
		endcase

		ok_c  = 1'b1;
		res_c = '0;
		hi_c  = '0;
		wr_c  = 1'b0;
		tk_c  = 1'b0;
		f_c   = flags_q;
		sb_c  = sb_q;
		unique case (op_s1)
			OP_ALU: begin
				ok_c  = alu_ok;
				res_c = alu_v[15:0];
				wr_c  = alu_wr;
				f_c   = alu_f;
			end
			OP_ASR, OP_LSR, OP_ROR, OP_ROL: begin
				ok_c = (code_s1 == ALU_LOAD);
				wr_c = 1'b1;
				unique case (op_s1)
					OP_ASR: begin
						res_c = asr_t[19:4];
						sb_c  = asr_t[3:0];
					end
					OP_LSR: begin
						res_c = lsr_t[19:4];
						sb_c  = lsr_t[3:0];
					end
					OP_ROR: begin
						res_c = ror_t[19:4];
						sb_c  = ror_t[3:0];
					end
					default: begin
						res_c = rol_t[19:4];
						sb_c  = rol_t[23:20];
					end
				endcase
				f_c = {res_c[15], res_c == 16'd0, flags_q[FL_S], flags_q[FL_C]};
			end
			OP_LSL: begin
				ok_c  = (code_s1 == ALU_ADD) || (code_s1 == ALU_LOAD) || (code_s1 == ALU_OR);
				res_c = alu_v[15:0];
				wr_c  = alu_wr;
				f_c   = alu_f;
				sb_c  = lsl_t[19:16];
			end
			OP_MULU, OP_MULS: begin
				res_c = prod[15:0];
				hi_c  = prod[31:16];
				wr_c  = 1'b1;
			end
			OP_BR: begin
				ok_c  = (code_s1 != CC_BAD);
				tk_c  = cond;
				res_c = back_s1 ? (a_s1 - b_s1) : (a_s1 + b_s1);
			end
			OP_LDST: begin
				f_c = b_s1[9:6];
			end
			default: ok_c = 1'b0;
		endcase

		if (!ok_c) begin
			res_c = '0;
			hi_c  = '0;
			wr_c  = 1'b0;
			tk_c  = 1'b0;
			f_c   = flags_q;
			sb_c  = sb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flags_q  <= '0;
			sb_q     <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				flags_q <= f_c;
				sb_q    <= sb_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2      <= res_c;
			result_high_s2 <= hi_c;
			write_s2       <= wr_c;
			taken_s2       <= tk_c;
			flags_s2       <= f_c;
			sb_s2          <= sb_c;
			error_s2       <= !ok_c;
		end
	end

	assign out_valid        = valid_s2;
	assign result           = result_s2;
	assign result_high      = result_high_s2;
	assign write_result     = write_s2;
	assign branch_taken     = taken_s2;
	assign flags_out        = flags_s2;
	assign shift_buffer_out = sb_s2;
	assign error            = error_s2;

`ifndef NO_ASSERTIONS
	a_state_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (flags_s2 == flags_q) && (sb_s2 == sb_q))
		else $error("architectural state differs from last delivered transaction");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && error_s2 |-> (result_s2 == 16'd0) && (result_high_s2 == 16'd0)
			&& !write_s2 && !taken_s2)
		else $error("error transaction carries a nonzero result");

	a_state_hold_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !ok_c |=> (flags_q == $past(flags_q)) && (sb_q == $past(sb_q)))
		else $error("state changed on unknown code");

	a_stage1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(a_s1) && $stable(op_s1))
		else $error("stage 1 transaction lost during stall");

	a_taken_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && taken_s2 |-> !write_s2 && (result_high_s2 == 16'd0))
		else $error("taken branch writes a result");
`endif

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

import cpu16_pkg::*;

typedef struct packed {
	code_t       op;
	code_t       code;
	logic [15:0] a;
	logic [15:0] b;
	logic [2:0]  cnt;
	logic        back;
} exec_op_t;

typedef struct packed {
	logic [15:0] res;
	logic [15:0] hi;
	logic        wr;
	logic        taken;
	logic [3:0]  fl;
	logic [3:0]  sbuf;
	logic        err;
} outcome_t;

class exec_scoreboard;
	logic [3:0] flags;
	logic [3:0] shbuf;
	outcome_t   awaited[$];
	int         errors;
	int         seen;

	function new();
		flags = '0;
		shbuf = '0;
		errors = 0;
		seen = 0;
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s", msg);
	endtask

	function logic cond_true(code_t cc, logic [3:0] f);
		logic c;
		case (cc)
			CC_CC: c = !f[FL_C];
			CC_CS: c = f[FL_C];
			CC_SC: c = !f[FL_S];
			CC_SS: c = f[FL_S];
			CC_NE: c = !f[FL_Z];
			CC_EQ: c = f[FL_Z];
			CC_PL: c = !f[FL_N];
			CC_MI: c = f[FL_N];
			CC_LS: c = !(f[FL_C] && !f[FL_Z]);
			CC_HI: c = f[FL_C] && !f[FL_Z];
			CC_LE: c = f[FL_Z] || f[FL_S];
			CC_GT: c = !(f[FL_Z] || f[FL_S]);
			CC_AL: c = 1'b1;
			default: c = 1'b0;
		endcase
		return c;
	endfunction

	function void alu_op(input code_t code, input logic [15:0] r0, input logic [15:0] r1,
			inout logic [3:0] f, output logic [15:0] res, output logic wr,
			output logic ok);
		logic [16:0] v;
		logic        arith;
		ok = 1'b1;
		arith = 1'b1;
		v = '0;
		case (code)
			ALU_ADD: v = r0 + r1;
			ALU_ADC: v = r0 + r1 + f[FL_C];
			ALU_SBC: v = r0 + {1'b0, ~r1} + f[FL_C];
			ALU_SUB, ALU_CMP: v = r0 + {1'b0, ~r1} + 17'd1;
			default: arith = 1'b0;
		endcase
		if (!arith) begin
			case (code)
				ALU_NEG: v = {1'b0, -r1};
				ALU_XOR: v = {1'b0, r0 ^ r1};
				ALU_LOAD: v = {1'b0, r1};
				ALU_OR: v = {1'b0, r0 | r1};
				ALU_AND, ALU_TEST: v = {1'b0, r0 & r1};
				default: ok = 1'b0;
			endcase
		end
		res = v[15:0];
		wr = (code != ALU_CMP) && (code < ALU_TEST);
		if (!ok)
			return;
		f[FL_N] = v[15];
		f[FL_Z] = (v[15:0] == 16'h0000);
		if (arith) begin
			f[FL_C] = v[16];
			f[FL_S] = $signed(r0) < $signed(r1);
		end
	endfunction

	function void take_operation(exec_op_t it);
		logic [3:0]         f;
		logic [3:0]         sb;
		logic [15:0]        res;
		logic [15:0]        hi;
		logic [15:0]        r1;
		logic               wr;
		logic               taken;
		logic               ok;
		logic [23:0]        t;
		logic [27:0]        tl;
		logic signed [31:0] p;
		int                 n;
		outcome_t           o;
		f = flags;
		sb = shbuf;
		res = '0;
		hi = '0;
		wr = 1'b0;
		taken = 1'b0;
		ok = 1'b1;
		n = ((int'(it.cnt) - 1) & 3) + 1;
		case (it.op)
			OP_ALU: alu_op(it.code, it.a, it.b, f, res, wr, ok);
			OP_ASR, OP_LSR, OP_ROR, OP_ROL: begin
				if (it.code != ALU_LOAD) begin
					ok = 1'b0;
				end else begin
					if (it.op == OP_ROL) begin
						tl = {4'h0, sb, it.b, sb} << n;
						sb = tl[23:20];
						res = tl[19:4];
					end else begin
						case (it.op)
							OP_ASR: t = {{4{it.b[15]}}, it.b, sb} >> n;
							OP_LSR: t = {4'h0, it.b, sb} >> n;
							default: t = {sb, it.b, sb} >> n;
						endcase
						sb = t[3:0];
						res = t[19:4];
					end
					f[FL_N] = res[15];
					f[FL_Z] = (res == 16'h0000);
					wr = 1'b1;
				end
			end
			OP_LSL: begin
				if (it.code != ALU_ADD && it.code != ALU_LOAD && it.code != ALU_OR) begin
					ok = 1'b0;
				end else begin
					t = {4'h0, sb, it.b} << n;
					sb = t[19:16];
					r1 = t[15:0];
					alu_op(it.code, it.a, r1, f, res, wr, ok);
				end
			end
			OP_MULU, OP_MULS: begin
				if (it.op == OP_MULU)
					p = $signed({1'b0, it.a}) * $signed(it.b);
				else
					p = $signed(it.a) * $signed(it.b);
				res = p[15:0];
				hi = p[31:16];
				wr = 1'b1;
			end
			OP_BR: begin
				if (it.code == CC_BAD) begin
					ok = 1'b0;
				end else begin
					taken = cond_true(it.code, f);
					res = it.back ? it.a - it.b : it.a + it.b;
				end
			end
			OP_LDST: begin
				f[FL_N] = it.b[9];
				f[FL_Z] = it.b[8];
				f[FL_S] = it.b[7];
				f[FL_C] = it.b[6];
			end
			default: ok = 1'b0;
		endcase
		if (!ok) begin
			o = '{res: '0, hi: '0, wr: 1'b0, taken: 1'b0, fl: flags, sbuf: shbuf, err: 1'b1};
		end else begin
			flags = f;
			shbuf = sb;
			o = '{res: res, hi: hi, wr: wr, taken: taken, fl: f, sbuf: sb, err: 1'b0};
		end
		awaited.push_back(o);
	endfunction

	task check_outcome(outcome_t got);
		outcome_t want;
		if (awaited.size() == 0) begin
			report($sformatf("#%0d result with no transaction pending", seen));
			seen++;
			return;
		end
		want = awaited.pop_front();
		if (got.res !== want.res)
			report($sformatf("#%0d result %h, expected %h", seen, got.res, want.res));
		if (got.hi !== want.hi)
			report($sformatf("#%0d result_high %h, expected %h", seen, got.hi, want.hi));
		if (got.wr !== want.wr)
			report($sformatf("#%0d write_result %b, expected %b", seen, got.wr, want.wr));
		if (got.taken !== want.taken)
			report($sformatf("#%0d branch_taken %b, expected %b", seen, got.taken,
				want.taken));
		if (got.fl !== want.fl)
			report($sformatf("#%0d flags_out %b, expected %b", seen, got.fl, want.fl));
		if (got.sbuf !== want.sbuf)
			report($sformatf("#%0d shift_buffer_out %h, expected %h", seen, got.sbuf,
				want.sbuf));
		if (got.err !== want.err)
			report($sformatf("#%0d error %b, expected %b", seen, got.err, want.err));
		seen++;
	endtask
endclass

module tb_top;
	import cpu16_pkg::*;

	localparam int STALL_PCT    = 14;
	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 1200;

	localparam code_t ALU_HOLE  = 4'd5;
	localparam code_t OP_UNUSED = 4'd12;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [3:0]  operation = '0;
	logic [3:0]  alu_code = '0;
	logic [15:0] operand_a = '0;
	logic [15:0] operand_b = '0;
	logic [2:0]  shift_count = 3'd1;
	logic        backward = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] result;
	logic [15:0] result_high;
	logic        write_result;
	logic        branch_taken;
	logic [3:0]  flags_out;
	logic [3:0]  shift_buffer_out;
	logic        error;

	exec_scoreboard board;
	outcome_t       observed;
	logic           calm = 1'b0;
	int             quiet = 0;

	code_t alu_codes[11] = '{ALU_ADD, ALU_ADC, ALU_SUB, ALU_SBC, ALU_CMP, ALU_NEG,
		ALU_XOR, ALU_LOAD, ALU_OR, ALU_AND, ALU_TEST};
	code_t lsl_codes[3] = '{ALU_ADD, ALU_LOAD, ALU_OR};

	cpu16_alu_shifter_flags_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.alu_code(alu_code),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.shift_count(shift_count),
		.backward(backward),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result),
		.result_high(result_high),
		.write_result(write_result),
		.branch_taken(branch_taken),
		.flags_out(flags_out),
		.shift_buffer_out(shift_buffer_out),
		.error(error)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic exec_op_t mk(code_t op, code_t code, logic [15:0] a, logic [15:0] b,
			logic [2:0] cnt, logic back);
		exec_op_t it;
		it = '{op: op, code: code, a: a, b: b, cnt: cnt, back: back};
		return it;
	endfunction

	function automatic logic [15:0] pick_word();
		logic [15:0] w;
		case ($urandom_range(0, 7))
			0: w = 16'h0000;
			1: w = 16'hffff;
			2: w = 16'h8000;
			3: w = 16'h7fff;
			4: w = 16'h0001;
			default: w = 16'($urandom);
		endcase
		return w;
	endfunction

	function automatic exec_op_t random_op();
		exec_op_t it;
		if ($urandom_range(0, 99) < 4)
			it.op = code_t'($urandom_range(int'(OP_LDST) + 1, 15));
		else
			it.op = code_t'($urandom_range(0, int'(OP_LDST)));
		if ($urandom_range(0, 99) < 20)
			it.op = OP_ALU;
		it.code = code_t'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < 85) begin
			case (it.op)
				OP_ALU: it.code = alu_codes[$urandom_range(0, 10)];
				OP_LSL: it.code = lsl_codes[$urandom_range(0, 2)];
				OP_ASR, OP_LSR, OP_ROR, OP_ROL: it.code = ALU_LOAD;
				default: ;
			endcase
		end
		it.a = pick_word();
		it.b = pick_word();
		if ($urandom_range(0, 99) < 90)
			it.cnt = 3'($urandom_range(1, 4));
		else
			it.cnt = 3'($urandom_range(0, 7));
		it.back = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic send_transaction(input exec_op_t it);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		operation <= it.op;
		alu_code <= it.code;
		operand_a <= it.a;
		operand_b <= it.b;
		shift_count <= it.cnt;
		backward <= it.back;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		board.take_operation(it);
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= arst_n && (calm || $urandom_range(0, 99) >= STALL_PCT);

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			observed = '{res: result, hi: result_high, wr: write_result, taken: branch_taken,
				fl: flags_out, sbuf: shift_buffer_out, err: error};
			board.check_outcome(observed);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= IDLE_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		exec_op_t directed[$];
		int       i;
		board = new();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed.push_back(mk(OP_ALU, ALU_ADD, 16'hffff, 16'h0001, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_ADC, 16'h7fff, 16'h0000, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_SUB, 16'h0000, 16'h0001, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_SBC, 16'h8000, 16'h7fff, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_CMP, 16'h1234, 16'h1234, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_NEG, 16'h0000, 16'h8000, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_XOR, 16'hffff, 16'h5555, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_LOAD, 16'hffff, 16'h0000, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_OR, 16'h00f0, 16'h0f00, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_AND, 16'hffff, 16'h8000, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_TEST, 16'h5555, 16'haaaa, 3'd1, 1'b0));
		directed.push_back(mk(OP_ALU, ALU_HOLE, 16'h1111, 16'h2222, 3'd1, 1'b0));
		directed.push_back(mk(OP_ASR, ALU_LOAD, 16'h0000, 16'h8001, 3'd4, 1'b0));
		directed.push_back(mk(OP_LSR, ALU_LOAD, 16'h0000, 16'hffff, 3'd1, 1'b0));
		directed.push_back(mk(OP_LSL, ALU_ADD, 16'h7fff, 16'h4001, 3'd2, 1'b0));
		directed.push_back(mk(OP_LSL, ALU_LOAD, 16'h0000, 16'hf00f, 3'd0, 1'b0));
		directed.push_back(mk(OP_LSL, ALU_OR, 16'h0001, 16'h8000, 3'd5, 1'b0));
		directed.push_back(mk(OP_ROR, ALU_LOAD, 16'h0000, 16'h1234, 3'd7, 1'b1));
		directed.push_back(mk(OP_ROL, ALU_LOAD, 16'h0000, 16'hffff, 3'd3, 1'b0));
		directed.push_back(mk(OP_ASR, ALU_ADD, 16'h0000, 16'hffff, 3'd2, 1'b0));
		directed.push_back(mk(OP_MULU, ALU_ADD, 16'hffff, 16'hffff, 3'd1, 1'b0));
		directed.push_back(mk(OP_MULS, ALU_TEST, 16'h8000, 16'h8000, 3'd1, 1'b0));
		directed.push_back(mk(OP_LDST, ALU_ADD, 16'hffff, 16'h03c0, 3'd1, 1'b0));
		directed.push_back(mk(OP_BR, CC_NV0, 16'h0010, 16'h0020, 3'd1, 1'b0));
		directed.push_back(mk(OP_BR, CC_AL, 16'h0000, 16'h0001, 3'd1, 1'b1));
		directed.push_back(mk(OP_BR, CC_BAD, 16'h1000, 16'h0010, 3'd1, 1'b0));
		directed.push_back(mk(OP_UNUSED, ALU_ADD, 16'h1234, 16'h5678, 3'd1, 1'b0));
		foreach (directed[j])
			send_transaction(directed[j]);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 500 && i < 800);
			send_transaction(random_op());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (board.awaited.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (board.errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
